### hw/rtl/utrc_pkg.sv
// Shared types and constants for the UART transmit ring with CR/LF expansion.
package utrc_pkg;

    localparam int BYTE_W = 8;
    localparam int DROP_W = 2;
    localparam int FILL_W = 4;

    localparam logic [BYTE_W-1:0] CH_LF = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_CR = 8'h0D;

    localparam logic MODE_PUT = 1'b0;
    localparam logic MODE_RDY = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CR,
        ST_RD,
        ST_OUT
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic start;    // request accepted: reload the result fields
        logic send_in;  // send the input character straight to the transmitter
        logic push;     // write one byte at the tail
        logic push_cr;  // pushed byte is a carriage return
        logic drop;     // count one lost character
        logic pop;      // read one byte at the head
        logic load_rd;  // capture the byte read from the ring
        logic irq_wr;   // update the interrupt enable
        logic irq_val;  // value for the interrupt enable
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic empty;
        logic full;
        logic last;     // exactly one byte queued
        logic mode;
        logic idle;
        logic is_lf;
    } status_t;

endpackage

### hw/rtl/utrc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module utrc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port and registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### hw/rtl/utrc_ctrl.sv
// Controller state machine: sequences put, carriage return, ring read and result hand-off.
module utrc_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    input  utrc_pkg::status_t st,
    output utrc_pkg::cmd_t    cmd
);

    utrc_pkg::state_t state_reg, state_next;
    logic             accept;

    assign accept = s_valid && (state_reg == utrc_pkg::ST_IDLE);

    // Hold state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= utrc_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            utrc_pkg::ST_IDLE: begin
                if (accept) begin
                    if (st.mode == utrc_pkg::MODE_PUT) begin
                        state_next = st.is_lf ? utrc_pkg::ST_CR : utrc_pkg::ST_OUT;
                    end else begin
                        state_next = st.empty ? utrc_pkg::ST_OUT : utrc_pkg::ST_RD;
                    end
                end
            end
            utrc_pkg::ST_CR:  state_next = utrc_pkg::ST_OUT;
            utrc_pkg::ST_RD:  state_next = utrc_pkg::ST_OUT;
            utrc_pkg::ST_OUT: begin
                if (m_ready) begin
                    state_next = utrc_pkg::ST_IDLE;
                end
            end
            default: state_next = utrc_pkg::ST_IDLE;
        endcase
    end

    // Outputs and datapath commands
    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        m_valid = 1'b0;
        unique case (state_reg)
            utrc_pkg::ST_IDLE: begin
                s_ready   = 1'b1;
                cmd.start = accept;
                if (accept) begin
                    cmd.irq_wr = 1'b1;
                    if (st.mode == utrc_pkg::MODE_PUT) begin
                        // bypass the ring when nothing waits and the line is idle
                        if (st.empty && st.idle) begin
                            cmd.send_in = 1'b1;
                            cmd.irq_val = 1'b0;
                        end else if (st.full) begin
                            cmd.drop    = 1'b1;
                            cmd.irq_val = 1'b1;
                        end else begin
                            cmd.push    = 1'b1;
                            cmd.irq_val = 1'b1;
                        end
                    end else begin
                        // drain one byte; disarm when the ring runs empty
                        cmd.pop     = !st.empty;
                        cmd.irq_val = !st.empty && !st.last;
                    end
                end
            end
            utrc_pkg::ST_CR: begin
                // carriage return queues unless the ring is full, the transmitter is busy
                cmd.irq_wr  = 1'b1;
                cmd.irq_val = 1'b1;
                cmd.drop    = st.full;
                cmd.push    = !st.full;
                cmd.push_cr = 1'b1;
            end
            utrc_pkg::ST_RD: begin
                cmd.load_rd = 1'b1;
            end
            utrc_pkg::ST_OUT: begin
                m_valid = 1'b1;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

### hw/rtl/utrc_dp.sv
// Datapath: ring pointers, fill count, interrupt enable, ring memory and result registers.
module utrc_dp #(
    parameter int RING_DEPTH = 16
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_mode,
    input  logic [utrc_pkg::BYTE_W-1:0]     s_char_in,
    input  logic                            s_tx_idle,
    input  utrc_pkg::cmd_t                  cmd,
    output utrc_pkg::status_t               st,
    output logic                            m_send_valid,
    output logic [utrc_pkg::BYTE_W-1:0]     m_send_byte,
    output logic                            m_irq_armed,
    output logic [utrc_pkg::DROP_W-1:0]     m_dropped,
    output logic [utrc_pkg::FILL_W-1:0]     m_fill_level
);

    localparam int PTR_W = $clog2(RING_DEPTH);

    logic [PTR_W-1:0] head_reg, head_next;
    logic [PTR_W-1:0] tail_reg, tail_next;
    logic [PTR_W-1:0] count_reg, count_next;
    logic             irq_reg, irq_next;

    logic                        send_reg, send_next;
    logic [utrc_pkg::BYTE_W-1:0] byte_reg, byte_next;
    logic [utrc_pkg::DROP_W-1:0] drop_reg, drop_next;

    logic [utrc_pkg::BYTE_W-1:0] wr_data;
    logic [utrc_pkg::BYTE_W-1:0] rd_data;
    logic [PTR_W+utrc_pkg::FILL_W-1:0] count_ext;

    // Ring storage
    utrc_ram #(
        .WIDTH (utrc_pkg::BYTE_W),
        .DEPTH (RING_DEPTH)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (cmd.push),
        .wr_addr (tail_reg),
        .wr_data (wr_data),
        .rd_en   (cmd.pop),
        .rd_addr (head_reg),
        .rd_data (rd_data)
    );

    assign wr_data = cmd.push_cr ? utrc_pkg::CH_CR : s_char_in;

    // Status toward the controller
    assign st.empty = (count_reg == '0);
    assign st.full  = (count_reg == PTR_W'(RING_DEPTH - 1));
    assign st.last  = (count_reg == PTR_W'(1));
    assign st.mode  = s_mode;
    assign st.idle  = s_tx_idle;
    assign st.is_lf = (s_char_in == utrc_pkg::CH_LF);

    // Advance pointers and fill count
    always_comb begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (cmd.push) begin
            tail_next  = (tail_reg == PTR_W'(RING_DEPTH - 1)) ? '0 : tail_reg + 1'b1;
            count_next = count_reg + 1'b1;
        end else if (cmd.pop) begin
            head_next  = (head_reg == PTR_W'(RING_DEPTH - 1)) ? '0 : head_reg + 1'b1;
            count_next = count_reg - 1'b1;
        end
        irq_next = cmd.irq_wr ? cmd.irq_val : irq_reg;
    end

    // Build the result fields
    always_comb begin
        send_next = send_reg;
        byte_next = byte_reg;
        drop_next = drop_reg + {1'b0, cmd.drop};
        if (cmd.start) begin
            send_next = cmd.send_in;
            byte_next = cmd.send_in ? s_char_in : '0;
            drop_next = {1'b0, cmd.drop};
        end else if (cmd.load_rd) begin
            send_next = 1'b1;
            byte_next = rd_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
            irq_reg   <= 1'b0;
        end else begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
            irq_reg   <= irq_next;
        end
    end

    always_ff @(posedge aclk) begin
        send_reg <= send_next;
        byte_reg <= byte_next;
        drop_reg <= drop_next;
    end

    // Fill level reports the count masked to four bits
    assign count_ext = {{utrc_pkg::FILL_W{1'b0}}, count_reg};

    assign m_send_valid = send_reg;
    assign m_send_byte  = byte_reg;
    assign m_irq_armed  = irq_reg;
    assign m_dropped    = drop_reg;
    assign m_fill_level = count_ext[utrc_pkg::FILL_W-1:0];

endmodule

### hw/rtl/uart_tx_ring_with_crlf.sv
// UART transmit ring buffer with line-feed to CR/LF expansion.
//
// Input channel (s_valid/s_ready): one request per character put (s_mode = 0)
// or per transmitter-ready event (s_mode = 1). A put with an empty ring and
// s_tx_idle high goes straight out on m_send_valid/m_send_byte; otherwise it
// is queued, or dropped when the ring is full, and the interrupt enable arms.
// A line feed queues a CR behind it. A ready event drains one queued byte.
// Result channel (m_valid/m_ready): exactly one result per request, carrying
// the sent byte, interrupt enable, dropped count and fill level.
// Timing: one request is in flight at a time. A plain put, or a ready event
// on an empty ring, shows its result in the cycle after acceptance; a line
// feed first passes through ST_CR (the carriage return write) and a draining
// ready event through ST_RD (the ring memory's registered read). s_ready
// returns the cycle after the result is taken.
// Reset (aresetn low, synchronous) empties the ring and disarms the
// interrupt; no clearing pass is needed. While m_ready is low the result
// holds and no new request is accepted.
module uart_tx_ring_with_crlf #(
    parameter int RING_DEPTH = 16
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_mode,
    input  logic [utrc_pkg::BYTE_W-1:0]     s_char_in,
    input  logic                            s_tx_idle,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic                            m_send_valid,
    output logic [utrc_pkg::BYTE_W-1:0]     m_send_byte,
    output logic                            m_irq_armed,
    output logic [utrc_pkg::DROP_W-1:0]     m_dropped,
    output logic [utrc_pkg::FILL_W-1:0]     m_fill_level
);

    utrc_pkg::cmd_t    cmd;
    utrc_pkg::status_t st;

    utrc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .st      (st),
        .cmd     (cmd)
    );

    utrc_dp #(
        .RING_DEPTH (RING_DEPTH)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_mode       (s_mode),
        .s_char_in    (s_char_in),
        .s_tx_idle    (s_tx_idle),
        .cmd          (cmd),
        .st           (st),
        .m_send_valid (m_send_valid),
        .m_send_byte  (m_send_byte),
        .m_irq_armed  (m_irq_armed),
        .m_dropped    (m_dropped),
        .m_fill_level (m_fill_level)
    );

endmodule

### hw/rtl/utrc_chk.sv
// Port-level checker for the UART transmit ring, bound to the top level.
module utrc_chk (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_valid,
    input logic                            s_ready,
    input logic                            s_mode,
    input logic [utrc_pkg::BYTE_W-1:0]     s_char_in,
    input logic                            s_tx_idle,
    input logic                            m_valid,
    input logic                            m_ready,
    input logic                            m_send_valid,
    input logic [utrc_pkg::BYTE_W-1:0]     m_send_byte,
    input logic                            m_irq_armed,
    input logic [utrc_pkg::DROP_W-1:0]     m_dropped,
    input logic [utrc_pkg::FILL_W-1:0]     m_fill_level
);

    // One request in flight: never ready while a result is pending
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("request accepted while a result is pending");

    // Accepting a request closes the input until its result is taken
    a_close_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input stayed open after a request");

    // At most two characters can be lost per request
    a_drop_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_dropped != 2'd3))
        else $error("dropped count out of range");

    // No byte shown unless one is sent
    a_byte_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_send_valid) |-> (m_send_byte == '0))
        else $error("byte nonzero without a send");

    // Stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_send_byte)
                                   && $stable(m_fill_level)))
        else $error("result changed while stalled");

endmodule

bind uart_tx_ring_with_crlf utrc_chk u_chk (.*);
